[hdl/pcrep_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcrep_pkg
// Shared types and constants of the per-cell RGB running-mean prior.
// ----------------------------------------------------------------------------
package pcrep_pkg;

  // Operation carried on the input tuser.
  localparam logic OP_BLEND = 1'b0;
  localparam logic OP_FOLD  = 1'b1;

  // Configuration register indexes.
  localparam logic REG_MIX_WEIGHT   = 1'b0;
  localparam logic REG_MIN_EVIDENCE = 1'b1;

  localparam int COLOR_W    = 8;
  localparam int MEAN_W     = 16;
  localparam int COUNT_W    = 8;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] MIX_WEIGHT_RST   = 16'd6554;
  localparam logic [7:0]  MIN_EVIDENCE_RST = 8'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic clr_step;  // write one zero into the count store
    logic load;      // capture the input transaction and read both stores
    logic calc;      // register the mix products
    logic fin;       // write back and load the output register
  } cmd_t;

  typedef struct packed {
    logic clr_last;  // clearing pass is at its last entry
    logic out_free;  // output register can take a result this cycle
  } status_t;

endpackage
`default_nettype wire

[hdl/pcrep_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcrep_ctrl
// Sequencer: clearing pass after reset, then accept, multiply, write back.
// ----------------------------------------------------------------------------
module pcrep_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  wire pcrep_pkg::status_t sts,
  output pcrep_pkg::cmd_t    cmd
);

  pcrep_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcrep_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      pcrep_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = pcrep_pkg::ST_IDLE;
        end
      end
      pcrep_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = pcrep_pkg::ST_CALC;
        end
      end
      pcrep_pkg::ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = pcrep_pkg::ST_FIN;
      end
      pcrep_pkg::ST_FIN: begin
        // Hold here while a previous result still sits in the output register.
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = pcrep_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pcrep_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

[hdl/pcrep_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcrep_datapath
// Mean and count stores, mix multipliers, blend logic and output register.
// ----------------------------------------------------------------------------
module pcrep_datapath #(
  parameter int CELL_COUNT = 65536
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire pcrep_pkg::cmd_t                 cmd,
  output pcrep_pkg::status_t                   sts,
  input  wire [pcrep_pkg::IN_DATA_W-1:0]       in_tdata,
  input  wire                                  in_tuser,
  input  wire                                  cfg_valid,
  input  wire                                  cfg_index,
  input  wire [pcrep_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [pcrep_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                 out_tuser
);

  localparam int AddrW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam logic [31:0] CellLimit = 32'(CELL_COUNT);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(CELL_COUNT - 1);

  // Configuration registers.
  logic [15:0] mix_weight_r;
  logic [7:0]  min_evidence_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_weight_r   <= pcrep_pkg::MIX_WEIGHT_RST;
      min_evidence_r <= pcrep_pkg::MIN_EVIDENCE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        pcrep_pkg::REG_MIX_WEIGHT:   mix_weight_r   <= cfg_data;
        pcrep_pkg::REG_MIN_EVIDENCE: min_evidence_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Input unpacking.
  logic [15:0]      in_cell;
  logic [15:0]      in_activity;
  logic [31:0]      in_cell_wide;
  logic [AddrW-1:0] in_addr;
  logic             in_act_ok;

  assign in_cell      = in_tdata[15:0];
  assign in_activity  = in_tdata[31:16];
  assign in_cell_wide = {16'd0, in_cell};
  assign in_addr      = in_cell_wide[AddrW-1:0];
  assign in_act_ok    = (in_activity != 16'd0) && (in_cell_wide < CellLimit);

  logic             op_r;
  logic             act_ok_r;
  logic [AddrW-1:0] addr_r;
  logic [7:0]       col_r [3];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_tuser;
      act_ok_r <= in_act_ok;
      addr_r   <= in_addr;
      col_r[0] <= in_tdata[39:32];
      col_r[1] <= in_tdata[47:40];
      col_r[2] <= in_tdata[55:48];
    end
  end

  // Clearing pass over the count store.
  logic [AddrW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_r + AddrW'(1);
    end
  end

  assign sts.clr_last = (clr_addr_r == LastAddr);

  // Stores. The mean store holds red, green, blue from the low bits up.
  logic [47:0]      mean_mem [CELL_COUNT];
  logic [7:0]       cnt_mem  [CELL_COUNT];
  logic [47:0]      mean_q_r;
  logic [7:0]       cnt_q_r;
  logic             fold_we;
  logic [47:0]      mean_wdata;
  logic             cnt_we;
  logic [AddrW-1:0] cnt_addr;
  logic [7:0]       cnt_wdata;
  logic [7:0]       cnt_inc;

  assign fold_we   = cmd.fin && act_ok_r && (op_r == pcrep_pkg::OP_FOLD);
  assign cnt_inc   = (cnt_q_r == 8'hFF) ? cnt_q_r : cnt_q_r + 8'd1;
  assign cnt_we    = cmd.clr_step || fold_we;
  assign cnt_addr  = cmd.clr_step ? clr_addr_r : addr_r;
  assign cnt_wdata = cmd.clr_step ? 8'd0 : cnt_inc;

  always_ff @(posedge clk) begin
    if (fold_we) begin
      mean_mem[addr_r] <= mean_wdata;
    end
    if (cmd.load) begin
      mean_q_r <= mean_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_addr] <= cnt_wdata;
    end
    if (cmd.load) begin
      cnt_q_r <= cnt_mem[in_addr];
    end
  end

  // Mix: mean + ((w * ((c << 8) - mean) + 0.5) >> 16), with an arithmetic
  // shift, equals the two-product weighted sum with half-up rounding.
  logic [15:0]        mean_ch   [3];
  logic signed [17:0] diff      [3];
  logic signed [34:0] prod      [3];
  logic signed [34:0] prod_r    [3];
  logic signed [34:0] rounded   [3];
  logic [15:0]        mixed     [3];
  logic [15:0]        new_mean  [3];
  logic [16:0]        blend_sum [3];
  logic [7:0]         blend_col [3];
  logic [7:0]         res_col   [3];
  logic signed [16:0] w_s;
  logic               all_zero;
  logic               blend_ok;

  assign w_s      = $signed({1'b0, mix_weight_r});
  assign all_zero = (col_r[0] == 8'd0) && (col_r[1] == 8'd0) && (col_r[2] == 8'd0);
  assign blend_ok = act_ok_r && (op_r == pcrep_pkg::OP_BLEND) && (cnt_q_r >= min_evidence_r);

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      mean_ch[ch]   = mean_q_r[16*ch +: 16];
      diff[ch]      = $signed({2'b00, col_r[ch], 8'd0}) - $signed({2'b00, mean_ch[ch]});
      prod[ch]      = 35'(diff[ch]) * 35'(w_s);
      rounded[ch]   = prod_r[ch] + 35'sd32768;
      mixed[ch]     = mean_ch[ch] + rounded[ch][31:16];
      new_mean[ch]  = (cnt_q_r == 8'd0) ? {col_r[ch], 8'd0} : mixed[ch];
      blend_sum[ch] = {1'b0, col_r[ch], 8'd0} + {1'b0, mean_ch[ch]};
      blend_col[ch] = all_zero ? mean_ch[ch][15:8] : blend_sum[ch][16:9];
      res_col[ch]   = blend_ok ? blend_col[ch] : col_r[ch];
    end
  end

  assign mean_wdata = {new_mean[2], new_mean[1], new_mean[0]};

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      for (int ch = 0; ch < 3; ch++) begin
        prod_r[ch] <= prod[ch];
      end
    end
  end

  // Output register.
  logic                              out_valid_r;
  logic [pcrep_pkg::OUT_DATA_W-1:0]  out_data_r;
  logic                              out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_data_r <= {res_col[2], res_col[1], res_col[0]};
      out_user_r <= blend_ok;
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser    = out_user_r;

endmodule
`default_nettype wire

[hdl/per_cell_rgb_ema_prior.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_cell_rgb_ema_prior
// Per-cell running mean of RGB in 8.8 fixed point with an evidence count;
// folds colors into the mean and blends the mean back into sparse colors.
//
// Channel  Direction  Contents
// in_      slave      tdata: cell_index, activity, red_in, green_in, blue_in
//                     tuser: operation (0 blend, 1 fold)
// out_     master     tdata: red_out, green_out, blue_out; tuser: was_blended
// cfg_     slave      index 0 mix_weight (Q0.16), index 1 min_evidence
//
// An item passes through accept with the store read, the mix multiply,
// then write-back with the result loaded into the output register; no new
// item is accepted until it is written back, keeping each read-modify-write whole.
// After reset a clearing pass over all CELL_COUNT entries zeroes the count
// store; no item is taken during it, configuration writes are.
// A result waiting on out_tready stalls the write-back cycle; the next item
// may already be accepted while the result waits.
// ----------------------------------------------------------------------------
module per_cell_rgb_ema_prior #(
  parameter int CELL_COUNT = 65536
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // [15:0] cell_index, [31:16] activity, [39:32] red_in, [47:40] green_in,
  // [55:48] blue_in
  input  wire [pcrep_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire                               in_tuser,   // [0] operation
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // [7:0] red_out, [15:8] green_out, [23:16] blue_out
  output logic [pcrep_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                              out_tuser,  // [0] was_blended
  output logic                              out_tvalid,
  input  wire                               out_tready,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire                               cfg_index,
  input  wire [pcrep_pkg::CFG_DATA_W-1:0]   cfg_data
);

  pcrep_pkg::cmd_t    cmd;
  pcrep_pkg::status_t sts;

  assign cfg_ready = 1'b1;

  pcrep_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pcrep_datapath #(
    .CELL_COUNT (CELL_COUNT)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

[hdl/pcrep_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcrep_checker
// Port-level checks of the prior block, bound to its top level.
// ----------------------------------------------------------------------------
module pcrep_checker (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               in_tvalid,
  input wire                               in_tready,
  input wire                               out_tvalid,
  input wire                               out_tready,
  input wire [pcrep_pkg::OUT_DATA_W-1:0]   out_tdata,
  input wire                               out_tuser
);

  // Reset empties the output and starts the clearing pass.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("output valid or input ready right after reset");

  // One transaction at a time: no input is taken in the cycle after one.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on two consecutive cycles");

  // A result cannot appear before the item has passed the multiply and write-back states.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared in the cycle after acceptance");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed or dropped");

endmodule

bind per_cell_rgb_ema_prior pcrep_checker u_pcrep_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the per-cell RGB running-mean prior. A shadow copy
// of the mean and count stores predicts every result in order. Directed
// cases come first. Random phases follow, each with its own register
// setting, against a burst-shaped sender and a receiver with changing stall styles.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 300000;  // well above the clearing pass
  localparam int LONG_HOLD      = 150;
  localparam int DRAIN_CYCLES   = 12;

  typedef struct packed {
    logic        op;
    logic [15:0] cell_idx;
    logic [15:0] activity;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } cell_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       blended;
  } prior_result_t;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_MASK, RX_STARVE} rx_style_t;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic [pcrep_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                             in_tuser   = pcrep_pkg::OP_BLEND;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [pcrep_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                             out_tuser;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic                             cfg_valid  = 1'b0;
  logic                             cfg_ready;
  logic                             cfg_index  = pcrep_pkg::REG_MIX_WEIGHT;
  logic [pcrep_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

  per_cell_rgb_ema_prior #(
    .CELL_COUNT(65536)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the block's stores and registers.
  bit [15:0]   avg_red   [65536];
  bit [15:0]   avg_green [65536];
  bit [15:0]   avg_blue  [65536];
  bit [7:0]    obs_count [65536];
  logic [15:0] mix_q16    = pcrep_pkg::MIX_WEIGHT_RST;
  logic [7:0]  needed_obs = pcrep_pkg::MIN_EVIDENCE_RST;

  // Generator-side bookkeeping, kept in stimulus order.
  bit          ever_folded [65536];
  logic [7:0]  gen_min_obs = pcrep_pkg::MIN_EVIDENCE_RST;

  cell_item_t    cell_stream[$];
  prior_result_t pending_colors[$];
  cell_item_t    offered;
  prior_result_t want;
  int            items_taken  = 0;
  int            err_count    = 0;
  int            gap_left     = 0;
  int            burst_left   = 1;
  int            hold_left    = 0;
  int            holds_done   = 0;
  int unsigned   rx_tick      = 0;
  rx_style_t     rx_style     = RX_FREE;
  logic [7:0]    rx_mask      = 8'hFF;
  int            quiet_cycles = 0;

  function automatic logic [15:0] mix_channel(logic [15:0] avg, logic [7:0] c);
    logic [47:0] acc;
    acc = (48'd65536 - 48'(mix_q16)) * 48'(avg) + 48'(mix_q16) * 48'({c, 8'h00})
          + 48'd32768;
    return acc[31:16];
  endfunction

  function automatic logic [7:0] blend_channel(logic [7:0] c, logic [15:0] avg,
                                               logic dark);
    logic [16:0] sum;
    sum = {1'b0, c, 8'h00} + {1'b0, avg};
    return dark ? avg[15:8] : sum[16:9];
  endfunction

  // Every 16-bit index lies inside the store, so only zero activity skips.
  function automatic prior_result_t apply_prior(cell_item_t it);
    prior_result_t res;
    logic          dark;
    int unsigned   idx;
    res = '{it.red, it.green, it.blue, 1'b0};
    idx = it.cell_idx;
    if (it.activity != 16'd0) begin
      if (it.op == pcrep_pkg::OP_FOLD) begin
        if (obs_count[idx] == 8'd0) begin
          avg_red[idx]   = {it.red, 8'h00};
          avg_green[idx] = {it.green, 8'h00};
          avg_blue[idx]  = {it.blue, 8'h00};
        end else begin
          avg_red[idx]   = mix_channel(avg_red[idx], it.red);
          avg_green[idx] = mix_channel(avg_green[idx], it.green);
          avg_blue[idx]  = mix_channel(avg_blue[idx], it.blue);
        end
        if (obs_count[idx] != 8'hFF) obs_count[idx] = obs_count[idx] + 8'd1;
      end else if (obs_count[idx] >= needed_obs) begin
        dark = (it.red == 8'd0) && (it.green == 8'd0) && (it.blue == 8'd0);
        res.red     = blend_channel(it.red, avg_red[idx], dark);
        res.green   = blend_channel(it.green, avg_green[idx], dark);
        res.blue    = blend_channel(it.blue, avg_blue[idx], dark);
        res.blended = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic queue_item(cell_item_t it);
    // With min_evidence at zero, a blend on a cell never folded would read a
    // mean that was never written, so such an item becomes a fold.
    if (it.op == pcrep_pkg::OP_BLEND && it.activity != 16'd0 && gen_min_obs == 8'd0 &&
        !ever_folded[it.cell_idx])
      it.op = pcrep_pkg::OP_FOLD;
    if (it.op == pcrep_pkg::OP_FOLD && it.activity != 16'd0)
      ever_folded[it.cell_idx] = 1'b1;
    cell_stream.push_back(it);
  endtask

  task automatic queue_directed(logic op, logic [15:0] cell_idx, logic [15:0] act,
                                logic [7:0] r, logic [7:0] g, logic [7:0] b);
    queue_item('{op, cell_idx, act, r, g, b});
  endtask

  // Most cells come from a small pool so that folds build up evidence.
  task automatic queue_random(int n, int pool_n, int fold_pct, int wide_pct);
    cell_item_t  it;
    int unsigned sel;
    for (int k = 0; k < n; k++) begin
      it.op = ($urandom_range(0, 99) < fold_pct) ? pcrep_pkg::OP_FOLD : pcrep_pkg::OP_BLEND;
      if ($urandom_range(0, 99) < wide_pct) it.cell_idx = 16'($urandom);
      else it.cell_idx = 16'($urandom_range(0, pool_n - 1) * 32'h2F5B);
      sel = $urandom_range(0, 99);
      if (sel < 12)      it.activity = 16'd0;
      else if (sel < 17) it.activity = 16'hFFFF;
      else if (sel < 22) it.activity = 16'd1;
      else               it.activity = 16'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        {it.red, it.green, it.blue} = '0;
      end else if (sel < 25) begin
        it.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        it.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        it.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else begin
        {it.red, it.green, it.blue} = 24'($urandom);
      end
      queue_item(it);
    end
  endtask

  task automatic cfg_write(logic idx, logic [pcrep_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic [15:0] weight, logic [7:0] min_obs);
    cfg_write(pcrep_pkg::REG_MIX_WEIGHT, weight);
    // The upper byte is ignored by the min_evidence register.
    cfg_write(pcrep_pkg::REG_MIN_EVIDENCE, {8'($urandom), min_obs});
    gen_min_obs = min_obs;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (cell_stream.size() != 0 || in_tvalid || pending_colors.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        pending_colors.push_back(apply_prior(offered));
        items_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (cell_stream.size() > 0) begin
          offered = cell_stream.pop_front();
          in_tdata  <= {offered.blue, offered.green, offered.red, offered.activity,
                        offered.cell_idx};
          in_tuser  <= offered.op;
          in_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: randomly changing stall styles, plus two long hold-offs
  // that let the block back up into its input.
  always @(posedge clk) begin
    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if ((holds_done == 0 && items_taken >= 300) ||
                 (holds_done == 1 && items_taken >= 900)) begin
      holds_done++;
      hold_left = LONG_HOLD;
      out_tready <= 1'b0;
    end else begin
      if (rx_tick % 64 == 0) begin
        rx_style = rx_style_t'($urandom_range(0, 3));
        rx_mask  = 8'($urandom);
      end
      case (rx_style)
        RX_FREE:  out_tready <= 1'b1;
        RX_COIN:  out_tready <= 1'($urandom_range(0, 1));
        RX_MASK:  out_tready <= rx_mask[rx_tick[2:0]];
        default:  out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_colors.size() == 0) begin
        $error("result transaction with none expected: tdata %h tuser %b",
               out_tdata, out_tuser);
        err_count++;
      end else begin
        want = pending_colors.pop_front();
        if (out_tdata[7:0] !== want.red) begin
          $error("red_out: expected %0d, got %0d", want.red, out_tdata[7:0]);
          err_count++;
        end
        if (out_tdata[15:8] !== want.green) begin
          $error("green_out: expected %0d, got %0d", want.green, out_tdata[15:8]);
          err_count++;
        end
        if (out_tdata[23:16] !== want.blue) begin
          $error("blue_out: expected %0d, got %0d", want.blue, out_tdata[23:16]);
          err_count++;
        end
        if (out_tuser !== want.blended) begin
          $error("was_blended: expected %0d, got %0d", want.blended, out_tuser);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        pcrep_pkg::REG_MIX_WEIGHT:   mix_q16 = cfg_data[15:0];
        pcrep_pkg::REG_MIN_EVIDENCE: needed_obs = cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $error("no transaction on any channel for %0d cycles", quiet_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset register values.
    queue_directed(pcrep_pkg::OP_BLEND, 16'd7, 16'h0001, 8'd10, 8'd20, 8'd30);  // no evidence
    queue_directed(pcrep_pkg::OP_FOLD, 16'd7, 16'h0000, 8'hFF, 8'hFF, 8'hFF);   // skipped
    queue_directed(pcrep_pkg::OP_FOLD, 16'd7, 16'hFFFF, 8'hFF, 8'h00, 8'h80);   // first value
    queue_directed(pcrep_pkg::OP_BLEND, 16'd7, 16'h0001, 8'd1, 8'd2, 8'd3);     // one short
    queue_directed(pcrep_pkg::OP_FOLD, 16'd7, 16'h8000, 8'h00, 8'hFF, 8'h01);
    queue_directed(pcrep_pkg::OP_BLEND, 16'd7, 16'h0001, 8'h00, 8'h00, 8'h00);
    queue_directed(pcrep_pkg::OP_BLEND, 16'd7, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    queue_directed(pcrep_pkg::OP_BLEND, 16'd7, 16'h0000, 8'h00, 8'h00, 8'h00);
    queue_directed(pcrep_pkg::OP_BLEND, 16'd7, 16'h0002, 8'h00, 8'h00, 8'h01);
    queue_directed(pcrep_pkg::OP_FOLD, 16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 8'h00);
    queue_directed(pcrep_pkg::OP_FOLD, 16'hFFFF, 16'h0001, 8'hFF, 8'hFF, 8'hFF);
    queue_directed(pcrep_pkg::OP_BLEND, 16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 8'h00);
    queue_directed(pcrep_pkg::OP_BLEND, 16'hFFFF, 16'h7FFF, 8'hFF, 8'h00, 8'hFF);
    queue_directed(pcrep_pkg::OP_FOLD, 16'h0000, 16'h00FF, 8'h80, 8'h80, 8'h80);
    queue_directed(pcrep_pkg::OP_FOLD, 16'h0000, 16'hFF00, 8'h7F, 8'h81, 8'h80);
    queue_directed(pcrep_pkg::OP_BLEND, 16'h0000, 16'hFF00, 8'h00, 8'h00, 8'h00);
    queue_directed(pcrep_pkg::OP_BLEND, 16'h0000, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    queue_directed(pcrep_pkg::OP_FOLD, 16'hAAAA, 16'h5555, 8'h55, 8'hAA, 8'hFF);
    queue_directed(pcrep_pkg::OP_FOLD, 16'h5555, 16'hAAAA, 8'hAA, 8'h55, 8'h00);
    queue_directed(pcrep_pkg::OP_BLEND, 16'h5555, 16'hAAAA, 8'h00, 8'h00, 8'h00);

    queue_random(300, 32, 55, 20);

    wait_drained();
    configure(16'd0, 8'd0);
    queue_random(150, 32, 50, 10);

    // Full weight on a single hot cell drives its count into saturation.
    wait_drained();
    configure(16'hFFFF, 8'hFF);
    queue_random(350, 1, 75, 0);

    wait_drained();
    configure(16'($urandom), 8'($urandom_range(1, 4)));
    queue_random(250, 16, 50, 20);

    wait_drained();
    configure(16'd1, 8'd1);
    queue_random(200, 64, 45, 25);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
